@@ hw/rtl/arpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned IN_DATA_W  = 240;
  localparam int unsigned OUT_DATA_W = 184;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [1:0] CMD_FRAME  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_SEND   = 2'd2;

  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;

  localparam logic [0:0] REG_LOCAL_IP  = 1'b0;
  localparam logic [0:0] REG_LOCAL_MAC = 1'b1;

  localparam logic [10:0] MIN_FRAME_LEN = 11'd42;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [15:0] OP_REQUEST    = 16'd1;
  localparam logic [15:0] OP_REPLY      = 16'd2;
  localparam logic [1:0]  FOP_REQUEST   = 2'd1;
  localparam logic [1:0]  FOP_REPLY     = 2'd2;
  localparam logic [47:0] MAC_BCAST     = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic       in_load;
    logic       scan_start;
    logic       scan_run;
    logic       tbl_write;
    logic       hit_set;
    logic       out_load;
    logic [1:0] out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       frame_ok;
    logic       is_reply;
    logic       is_request;
    logic       tip_match;
    logic       cmp_vld;
    logic       cmp_used;
    logic       cmp_match;
    logic       cmp_last;
    logic       out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/arpc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_ctrl
// Controller: sequences decode, table scan and result hand-off per item.
// ----------------------------------------------------------------------------
module arpc_ctrl
  import arpc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] kind_q, kind_d;
  logic       learn_q, learn_d;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    learn_d    = learn_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_kind = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        unique case (status_i.cmd)
          CMD_FRAME: begin
            if (status_i.frame_ok && status_i.is_reply) begin
              cmd_o.scan_start = 1'b1;
              learn_d          = 1'b1;
              state_d          = ST_SCAN;
            end else if (status_i.frame_ok && status_i.is_request &&
                         status_i.tip_match) begin
              kind_d  = KIND_REPLY;
              state_d = ST_EMIT;
            end
          end
          CMD_LOOKUP: begin
            cmd_o.scan_start = 1'b1;
            learn_d          = 1'b0;
            kind_d           = KIND_LOOKUP;
            state_d          = ST_SCAN;
          end
          CMD_SEND: begin
            kind_d  = KIND_REQUEST;
            state_d = ST_EMIT;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.cmp_vld) begin
          if (learn_q) begin
            if (!status_i.cmp_used || status_i.cmp_match) begin
              cmd_o.tbl_write = 1'b1;
              cmd_o.scan_run  = 1'b0;
              state_d         = ST_IDLE;
            end else if (status_i.cmp_last) begin
              cmd_o.scan_run = 1'b0;
              state_d        = ST_IDLE;
            end
          end else begin
            if (status_i.cmp_used && status_i.cmp_match) begin
              cmd_o.hit_set  = 1'b1;
              cmd_o.scan_run = 1'b0;
              state_d        = ST_EMIT;
            end else if (status_i.cmp_last) begin
              cmd_o.scan_run = 1'b0;
              state_d        = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_REPLY;
      learn_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      learn_q <= learn_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/arpc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_dp
// Datapath: item registers, local address registers, cache table with
// pipelined scan, and the output register.
// ----------------------------------------------------------------------------
module arpc_dp
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [0:0]            cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [1:0]            in_cmd_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [1:0]                 out_kind_o,
  output logic [OUT_DATA_W-1:0]      out_data_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [31:0] local_ip_q;
  logic [47:0] local_mac_q;

  logic [1:0]  cmd_q;
  logic [10:0] flen_q;
  logic [15:0] ptype_q;
  logic [15:0] op_q;
  logic [47:0] esrc_q;
  logic [47:0] smac_q;
  logic [31:0] sip_q;
  logic [31:0] tip_q;
  logic [31:0] qip_q;

  logic [31:0] mem_ip  [TABLE_ENTRIES];
  logic [47:0] mem_mac [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic [CNT_W-1:0] rd_cnt_q;
  logic [IDX_W-1:0] rd_idx;
  logic             issue;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             cmp_vld_q;
  logic             cmp_used_q;
  logic [31:0]      cmp_ip_q;
  logic [47:0]      cmp_mac_q;
  logic             hit_q;

  logic             out_valid_q;
  logic [1:0]       out_kind_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_DATA_W-1:0] out_data_d;
  logic [47:0] o_dest;
  logic [1:0]  o_op;
  logic [47:0] o_tmac;
  logic [31:0] o_tip;
  logic        o_hit;
  logic [47:0] o_fmac;

  assign rd_idx = rd_cnt_q[IDX_W-1:0];
  assign issue  = cmd_i.scan_run && (rd_cnt_q < CNT_W'(TABLE_ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q  <= '0;
      local_mac_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LOCAL_IP:  local_ip_q  <= cfg_wdata_i[31:0];
        REG_LOCAL_MAC: local_mac_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      cmd_q   <= in_cmd_i;
      flen_q  <= in_data_i[10:0];
      ptype_q <= in_data_i[26:11];
      op_q    <= in_data_i[42:27];
      esrc_q  <= in_data_i[90:43];
      smac_q  <= in_data_i[138:91];
      sip_q   <= in_data_i[170:139];
      tip_q   <= in_data_i[202:171];
      qip_q   <= in_data_i[234:203];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_write) begin
      mem_ip[cmp_idx_q]  <= sip_q;
      mem_mac[cmp_idx_q] <= smac_q;
    end
    if (issue) begin
      cmp_ip_q  <= mem_ip[rd_idx];
      cmp_mac_q <= mem_mac[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_cnt_q   <= '0;
      cmp_idx_q  <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_used_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      if (cmd_i.tbl_write) begin
        valid_q[cmp_idx_q] <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        rd_cnt_q  <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end else if (cmd_i.scan_run) begin
        cmp_vld_q <= issue;
        if (issue) begin
          rd_cnt_q   <= rd_cnt_q + CNT_W'(1);
          cmp_idx_q  <= rd_idx;
          cmp_used_q <= valid_q[rd_idx];
        end
      end
      if (cmd_i.hit_set) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.cmd        = cmd_q;
    status_o.frame_ok   = (flen_q >= MIN_FRAME_LEN) && (ptype_q == PROTO_IPV4);
    status_o.is_reply   = (op_q == OP_REPLY);
    status_o.is_request = (op_q == OP_REQUEST);
    status_o.tip_match  = (tip_q == local_ip_q);
    status_o.cmp_vld    = cmp_vld_q;
    status_o.cmp_used   = cmp_used_q;
    status_o.cmp_match  = (cmp_ip_q == sip_q && cmd_q == CMD_FRAME) ||
                          (cmp_ip_q == qip_q && cmd_q == CMD_LOOKUP);
    status_o.cmp_last   = (cmp_idx_q == IDX_W'(TABLE_ENTRIES - 1));
    status_o.out_busy   = out_valid_q && !out_ready_i;
  end

  always_comb begin
    o_dest = '0;
    o_op   = '0;
    o_tmac = '0;
    o_tip  = '0;
    o_hit  = 1'b0;
    o_fmac = '0;
    case (cmd_i.out_kind)
      KIND_REPLY: begin
        o_dest = esrc_q;
        o_op   = FOP_REPLY;
        o_tmac = smac_q;
        o_tip  = sip_q;
      end
      KIND_REQUEST: begin
        o_dest = MAC_BCAST;
        o_op   = FOP_REQUEST;
        o_tip  = qip_q;
      end
      KIND_LOOKUP: begin
        o_hit  = hit_q;
        o_fmac = hit_q ? cmp_mac_q : 48'd0;
      end
      default: ;
    endcase
    out_data_d = {5'd0, o_fmac, o_hit, o_tip, o_tmac, o_op, o_dest};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

@@ hw/rtl/arp_cache_and_responder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_cache_and_responder
// ARP cache of IPv4-to-MAC entries with a responder for ARP requests.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser carries the command (received
// frame, lookup, send request) and tdata the parsed frame fields and query
// address. Results leave on the m_axis channel: tuser carries the result
// kind (reply frame, request frame, lookup answer), tdata the frame fields,
// hit flag and found MAC. An item gives at most one result.
// The local IP and MAC are written through the cfg port; the user must write
// them only while idle, as the block itself does not enforce it.
// The block takes one item at a time. An item that needs no table access
// and gives a result is loaded into the result register from the emit
// state, and the controller then returns to idle for the next item. A learn
// or lookup scans the table through one registered read port, one entry per
// cycle.
// The result sits in an output register, so the next item is accepted while
// a result waits; if the receiver stalls, the next result waits in the
// controller until the register is free.
// Reset clears all valid marks of the table at once and the local address
// registers to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_cache_and_responder
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [0:0]            cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0: frame_len, proto_type, opcode, eth_src_mac,
  // sender_mac, sender_ip, ARP target IP, query_ip, zero fill.
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Field: cmd.
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // Fields from bit 0: frame_dest_mac, frame_opcode, frame_target_mac,
  // frame target IP, hit, found_mac, zero fill.
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // Field: out_kind.
  output logic [1:0]                 m_axis_tuser
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  arpc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the ARP cache and responder. Frames, lookups and
// send commands go in on the input stream. A behavioral copy of the address
// table predicts the expected result of each accepted item. Every result is
// checked field by field against the oldest prediction, under random idling on
// both sides, a long receiver stall and several local address settings.
// ----------------------------------------------------------------------------
module tb;
  import arpc_pkg::*;

  localparam int unsigned TBL_DEPTH     = 16;
  localparam int unsigned SETTLE_CYCLES = 2 * (TBL_DEPTH + 4);
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_ITEMS   = 320;
  localparam int unsigned IP_POOL_SIZE  = 24;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;

  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] query_ip;
    logic [31:0] tgt_ip;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [47:0] eth_src_mac;
    logic [15:0] opcode;
    logic [15:0] proto_type;
    logic [10:0] frame_len;
  } arp_fields_t;

  typedef struct packed {
    logic [1:0]  cmd;
    arp_fields_t f;
  } arp_item_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [47:0] found_mac;
    logic        hit;
    logic [31:0] tgt_ip;
    logic [47:0] target_mac;
    logic [1:0]  opcode;
    logic [47:0] dest_mac;
  } arp_frame_t;

  typedef struct packed {
    logic [1:0] kind;
    arp_frame_t d;
  } arp_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [0:0]            cfg_addr_i    = REG_LOCAL_IP;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = CMD_FRAME;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  logic [31:0] own_ip = '0;
  logic [47:0] own_mac = '0;
  logic [31:0] tbl_ip [TBL_DEPTH];
  logic [47:0] tbl_mac [TBL_DEPTH];
  bit          tbl_vld [TBL_DEPTH];
  logic [31:0] ip_pool [IP_POOL_SIZE];
  arp_result_t pending_results [$];

  bit          gaps_on      = 1'b1;
  int unsigned hold_req_id  = 0;
  int unsigned hold_seen_id = 0;
  int unsigned hold_left    = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;

  arp_cache_and_responder #(
    .TABLE_ENTRIES(TBL_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic bit predict_arp(input arp_item_t it, output arp_result_t res);
    bit done;
    res = '0;
    done = 1'b0;
    case (it.cmd)
      CMD_FRAME: begin
        if (it.f.frame_len < MIN_FRAME_LEN || it.f.proto_type != PROTO_IPV4) return 1'b0;
        if (it.f.opcode == OP_REPLY) begin
          for (int i = 0; i < TBL_DEPTH; i++) begin
            if (!done && (!tbl_vld[i] || tbl_ip[i] == it.f.sender_ip)) begin
              tbl_ip[i] = it.f.sender_ip;
              tbl_mac[i] = it.f.sender_mac;
              tbl_vld[i] = 1'b1;
              done = 1'b1;
            end
          end
          return 1'b0;
        end
        if (it.f.opcode == OP_REQUEST && it.f.tgt_ip == own_ip) begin
          res.kind = KIND_REPLY;
          res.d.dest_mac = it.f.eth_src_mac;
          res.d.opcode = FOP_REPLY;
          res.d.target_mac = it.f.sender_mac;
          res.d.tgt_ip = it.f.sender_ip;
          return 1'b1;
        end
        return 1'b0;
      end
      CMD_LOOKUP: begin
        res.kind = KIND_LOOKUP;
        for (int i = 0; i < TBL_DEPTH; i++) begin
          if (!done && tbl_vld[i] && tbl_ip[i] == it.f.query_ip) begin
            res.d.hit = 1'b1;
            res.d.found_mac = tbl_mac[i];
            done = 1'b1;
          end
        end
        return 1'b1;
      end
      CMD_SEND: begin
        res.kind = KIND_REQUEST;
        res.d.dest_mac = MAC_BCAST;
        res.d.opcode = FOP_REQUEST;
        res.d.tgt_ip = it.f.query_ip;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic arp_item_t rand_item();
    arp_item_t it;
    it.cmd = 2'($urandom_range(3));
    it.f.pad = '0;
    it.f.frame_len = 11'($urandom_range(2047));
    it.f.proto_type = 16'($urandom);
    it.f.opcode = 16'($urandom);
    it.f.eth_src_mac = rand48();
    it.f.sender_mac = rand48();
    it.f.sender_ip = $urandom;
    it.f.tgt_ip = $urandom;
    it.f.query_ip = $urandom;
    return it;
  endfunction

  function automatic arp_item_t frame_item(input logic [10:0] len, input logic [15:0] proto,
                                           input logic [15:0] op, input logic [31:0] sip,
                                           input logic [31:0] tip);
    arp_item_t it;
    it = rand_item();
    it.cmd = CMD_FRAME;
    it.f.frame_len = len;
    it.f.proto_type = proto;
    it.f.opcode = op;
    it.f.sender_ip = sip;
    it.f.tgt_ip = tip;
    return it;
  endfunction

  function automatic arp_item_t query_item(input logic [1:0] cmd, input logic [31:0] qip);
    arp_item_t it;
    it = rand_item();
    it.cmd = cmd;
    it.f.query_ip = qip;
    return it;
  endfunction

  function automatic arp_item_t random_item();
    arp_item_t   it;
    int unsigned pick;
    int unsigned idx;
    logic [31:0] known_ip;
    it = rand_item();
    pick = $urandom_range(99);
    idx = $urandom_range(TBL_DEPTH - 1);
    if (tbl_vld[idx] && $urandom_range(1) != 0) known_ip = tbl_ip[idx];
    else known_ip = ip_pool[$urandom_range(IP_POOL_SIZE - 1)];
    if (pick < 45) begin
      it.cmd = CMD_FRAME;
      it.f.frame_len = ($urandom_range(3) == 0) ? MIN_FRAME_LEN
                                                : 11'($urandom_range(42, 2047));
      it.f.proto_type = PROTO_IPV4;
      it.f.opcode = ($urandom_range(1) != 0) ? OP_REPLY : OP_REQUEST;
      it.f.sender_ip = known_ip;
      if ($urandom_range(3) != 0) it.f.tgt_ip = own_ip;
    end else if (pick < 65) begin
      it.cmd = CMD_LOOKUP;
      if ($urandom_range(4) != 0) it.f.query_ip = known_ip;
    end else if (pick < 78) begin
      it.cmd = CMD_SEND;
    end else if (pick < 88) begin
      it.cmd = CMD_FRAME;
      it.f.frame_len = 11'($urandom_range(42, 2047));
      it.f.proto_type = PROTO_IPV4;
      it.f.opcode = OP_REQUEST;
      it.f.tgt_ip = own_ip;
      case ($urandom_range(2))
        0: it.f.frame_len = 11'($urandom_range(41));
        1: it.f.proto_type = 16'($urandom);
        default: it.f.opcode = 16'($urandom);
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input arp_item_t it);
    arp_result_t res;
    while (gaps_on && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it.f;
    s_axis_tuser <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_arp(it, res)) pending_results.push_back(res);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] ip, input logic [47:0] mac);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= REG_LOCAL_IP;
    cfg_wdata_i <= CFG_DATA_W'(ip);
    @(posedge clk_i);
    own_ip = ip;
    cfg_addr_i <= REG_LOCAL_MAC;
    cfg_wdata_i <= mac;
    @(posedge clk_i);
    own_mac = mac;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    logic [31:0] peer_ip;
    arp_item_t   it;
    peer_ip = $urandom;
    set_config($urandom, rand48());
    send_item(frame_item(11'd41, PROTO_IPV4, OP_REQUEST, peer_ip, own_ip));
    send_item(frame_item(11'd0, PROTO_IPV4, OP_REPLY, peer_ip, own_ip));
    send_item(frame_item(MIN_FRAME_LEN, PROTO_IPV4, OP_REQUEST, peer_ip, own_ip));
    send_item(frame_item(11'd2047, PROTO_IPV4, OP_REQUEST, peer_ip, own_ip));
    send_item(frame_item(11'd60, 16'h0806, OP_REQUEST, peer_ip, own_ip));
    send_item(frame_item(11'd60, 16'hFFFF, OP_REPLY, peer_ip, own_ip));
    send_item(frame_item(11'd60, 16'h0000, OP_REQUEST, peer_ip, own_ip));
    send_item(frame_item(11'd60, PROTO_IPV4, 16'h0000, peer_ip, own_ip));
    send_item(frame_item(11'd60, PROTO_IPV4, 16'h0003, peer_ip, own_ip));
    send_item(frame_item(11'd60, PROTO_IPV4, 16'hFFFF, peer_ip, own_ip));
    send_item(frame_item(11'd60, PROTO_IPV4, 16'h0201, peer_ip, own_ip));
    send_item(frame_item(11'd60, PROTO_IPV4, OP_REQUEST, peer_ip, ~own_ip));
    send_item(query_item(CMD_LOOKUP, peer_ip));
    send_item(frame_item(11'd60, PROTO_IPV4, OP_REPLY, peer_ip, own_ip));
    send_item(query_item(CMD_LOOKUP, peer_ip));
    send_item(frame_item(11'd60, PROTO_IPV4, OP_REPLY, peer_ip, $urandom));
    send_item(query_item(CMD_LOOKUP, peer_ip));
    it = frame_item(11'd60, PROTO_IPV4, OP_REPLY, ~peer_ip, own_ip);
    it.cmd = CMD_UNUSED;
    send_item(it);
    send_item(query_item(CMD_LOOKUP, ~peer_ip));
    send_item(query_item(CMD_LOOKUP, 32'hFFFF_FFFF));
    send_item(query_item(CMD_SEND, 32'h0000_0000));
    send_item(query_item(CMD_SEND, 32'hFFFF_FFFF));
    it = frame_item(11'd2047, PROTO_IPV4, OP_REQUEST, 32'hFFFF_FFFF, own_ip);
    it.f.eth_src_mac = MAC_BCAST;
    it.f.sender_mac = '0;
    send_item(it);
    it = frame_item(MIN_FRAME_LEN, PROTO_IPV4, OP_REQUEST, 32'h0000_0000, own_ip);
    it.f.eth_src_mac = '0;
    it.f.sender_mac = MAC_BCAST;
    send_item(it);
    wait_idle();
  endtask

  task automatic test_table_full();
    logic [31:0] ip;
    logic [31:0] late_ips [2];
    for (int n = 0; n < TBL_DEPTH + 2; n++) begin
      ip = $urandom;
      late_ips[n % 2] = ip;
      send_item(frame_item(11'($urandom_range(42, 2047)), PROTO_IPV4, OP_REPLY, ip, $urandom));
    end
    send_item(query_item(CMD_LOOKUP, late_ips[0]));
    send_item(query_item(CMD_LOOKUP, late_ips[1]));
    send_item(query_item(CMD_LOOKUP, tbl_ip[0]));
    send_item(frame_item(11'd64, PROTO_IPV4, OP_REPLY, tbl_ip[TBL_DEPTH - 1], $urandom));
    send_item(query_item(CMD_LOOKUP, tbl_ip[TBL_DEPTH - 1]));
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_req_id <= hold_req_id + 1;
    for (int n = 0; n < 12; n++) begin
      send_item(query_item(n[0] ? CMD_SEND : CMD_LOOKUP, tbl_ip[n % TBL_DEPTH]));
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [31:0] cfg_ips [4];
    logic [47:0] cfg_macs [4];
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    cfg_ips = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, ip_pool[0]};
    cfg_macs = '{MAC_BCAST, 48'h0, rand48(), rand48()};
    for (int p = 0; p < 4; p++) begin
      set_config(cfg_ips[p], cfg_macs[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        gaps_on = !(p == 1 && n < 200);
        send_item(random_item());
      end
      wait_idle();
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req_id != hold_seen_id) begin
      hold_seen_id = hold_req_id;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !gaps_on || ($urandom_range(99) >= 26);
    end
  end

  function automatic void report_mismatch(input string what, input arp_result_t want,
                                          input arp_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch, %s: exp/act kind %0d/%0d dest %h/%h op %0d/%0d",
               what, want.kind, got.kind, want.d.dest_mac, got.d.dest_mac,
               want.d.opcode, got.d.opcode);
      $display("  tmac %h/%h tip %h/%h hit %b/%b fmac %h/%h",
               want.d.target_mac, got.d.target_mac, want.d.tgt_ip, got.d.tgt_ip,
               want.d.hit, got.d.hit, want.d.found_mac, got.d.found_mac);
    end
  endfunction

  always @(posedge clk_i) begin
    arp_result_t got;
    arp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.d = m_axis_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.d.dest_mac !== want.d.dest_mac ||
            got.d.opcode !== want.d.opcode || got.d.target_mac !== want.d.target_mac ||
            got.d.tgt_ip !== want.d.tgt_ip || got.d.hit !== want.d.hit ||
            got.d.found_mac !== want.d.found_mac) begin
          report_mismatch("wrong field", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("arp_cache_and_responder verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random_traffic();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("arp_cache_and_responder verification clean");
    end else begin
      $display("arp_cache_and_responder verification failed");
    end
    $finish;
  end

endmodule
